// ===== hw/rtl/ubxf_pkg.sv =====
// Shared types and constants for the UBX message framer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ubxf_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Step index inside one command (up to five output words)
   localparam int STEP_W = 3;

   typedef enum logic [1:0] {
      PH_CLASS,
      PH_ID,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [2:0] {
      KIND_CLASS,
      KIND_ID,
      KIND_ID_EMPTY,
      KIND_PAYLOAD,
      KIND_LAST
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] length;
      logic [7:0]  ck_a;
      logic [7:0]  ck_b;
   } cmd_type;

endpackage

// ===== hw/rtl/ubxf_front.sv =====
// Front end: accepts message bytes, tracks frame position, runs the checksums.
// Emits one command per accepted byte into the queue. Depends on ubxf_pkg.
`timescale 1ns / 1ps

module ubxf_front import ubxf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_msg_byte,
   input  logic [15:0] req_payload_length,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_data
);

   phase_type   phase_ff, phase_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;

   logic        take;
   logic        len_zero;
   logic        last_payload;
   logic [7:0]  id_a1, id_b1, id_a2, id_b2, id_a3, id_b3;
   logic [7:0]  pl_a, pl_b;

   assign take         = req_push && !q_full;
   assign q_push       = take;
   assign len_zero     = (len_ff == 16'd0);
   assign last_payload = (remaining_ff == 16'd1);

   // Id step folds in id, length low and length high
   assign id_a1 = sum_a_ff + req_msg_byte;
   assign id_b1 = sum_b_ff + id_a1;
   assign id_a2 = id_a1 + len_ff[7:0];
   assign id_b2 = id_b1 + id_a2;
   assign id_a3 = id_a2 + len_ff[15:8];
   assign id_b3 = id_b2 + id_a3;

   assign pl_a = sum_a_ff + req_msg_byte;
   assign pl_b = sum_b_ff + pl_a;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_CLASS:   phase_in = PH_ID;
            PH_ID:      phase_in = len_zero ? PH_CLASS : PH_PAYLOAD;
            PH_PAYLOAD: phase_in = last_payload ? PH_CLASS : PH_PAYLOAD;
            default:    phase_in = PH_CLASS;
         endcase
      end
   end

   // Outputs and datapath
   always_comb begin
      len_in        = len_ff;
      remaining_in  = remaining_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      q_data.kind   = KIND_CLASS;
      q_data.data   = req_msg_byte;
      q_data.length = len_ff;
      q_data.ck_a   = sum_a_ff;
      q_data.ck_b   = sum_b_ff;
      unique case (phase_ff)
         PH_CLASS: begin
            // sums restart from zero with the class word
            q_data.kind = KIND_CLASS;
            if (take) begin
               len_in   = req_payload_length;
               sum_a_in = req_msg_byte;
               sum_b_in = req_msg_byte;
            end
         end
         PH_ID: begin
            q_data.kind = len_zero ? KIND_ID_EMPTY : KIND_ID;
            q_data.ck_a = id_a3;
            q_data.ck_b = id_b3;
            if (take) begin
               remaining_in = len_ff;
               sum_a_in     = id_a3;
               sum_b_in     = id_b3;
            end
         end
         PH_PAYLOAD: begin
            q_data.kind = last_payload ? KIND_LAST : KIND_PAYLOAD;
            q_data.ck_a = pl_a;
            q_data.ck_b = pl_b;
            if (take) begin
               remaining_in = remaining_ff - 16'd1;
               sum_a_in     = pl_a;
               sum_b_in     = pl_b;
            end
         end
         default: begin
            q_data.kind = KIND_CLASS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CLASS;
         len_ff       <= '0;
         remaining_ff <= '0;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         remaining_ff <= remaining_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
      end
   end

endmodule

// ===== hw/rtl/ubxf_cmd_fifo.sv =====
// Short command queue between the front end and the output sequencer.
// Flip-flop storage, head visible without a read cycle. Depends on ubxf_pkg.
`timescale 1ns / 1ps

module ubxf_cmd_fifo import ubxf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   output logic    head_valid,
   output cmd_type head,
   input  logic    pop
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/ubxf_back.sv =====
// Output sequencer: expands each queued command into one to five wire words.
// Holds the result in an output register. Depends on ubxf_pkg.
`timescale 1ns / 1ps

module ubxf_back import ubxf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head,
   output logic       head_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              run_last_ff, run_last_in;
   logic              frame_last_ff, frame_last_in;

   logic              load;
   logic              sel_end;

   assign load = head_valid && (!valid_ff || rsp_pop);

   // Pick the word for the current step of the head command
   always_comb begin
      byte_in       = head.data;
      run_last_in   = 1'b0;
      frame_last_in = 1'b0;
      sel_end       = 1'b0;
      unique case (head.kind)
         KIND_CLASS: begin
            unique case (step_ff)
               3'd0:    byte_in = SYNC_FIRST;
               3'd1:    byte_in = SYNC_SECOND;
               default: begin
                  byte_in     = head.data;
                  run_last_in = 1'b1;
                  sel_end     = 1'b1;
               end
            endcase
         end
         KIND_ID: begin
            unique case (step_ff)
               3'd0:    byte_in = head.data;
               3'd1:    byte_in = head.length[7:0];
               default: begin
                  byte_in     = head.length[15:8];
                  run_last_in = 1'b1;
                  sel_end     = 1'b1;
               end
            endcase
         end
         KIND_ID_EMPTY: begin
            unique case (step_ff)
               3'd0:    byte_in = head.data;
               3'd1:    byte_in = head.length[7:0];
               3'd2:    byte_in = head.length[15:8];
               3'd3:    byte_in = head.ck_a;
               default: begin
                  byte_in       = head.ck_b;
                  run_last_in   = 1'b1;
                  frame_last_in = 1'b1;
                  sel_end       = 1'b1;
               end
            endcase
         end
         KIND_PAYLOAD: begin
            byte_in     = head.data;
            run_last_in = 1'b1;
            sel_end     = 1'b1;
         end
         KIND_LAST: begin
            unique case (step_ff)
               3'd0:    byte_in = head.data;
               3'd1:    byte_in = head.ck_a;
               default: begin
                  byte_in       = head.ck_b;
                  run_last_in   = 1'b1;
                  frame_last_in = 1'b1;
                  sel_end       = 1'b1;
               end
            endcase
         end
         default: begin
            sel_end = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = sel_end ? '0 : step_ff + STEP_W'(1);
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   assign head_pop       = load && sel_end;
   assign rsp_empty      = !valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_last = frame_last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= byte_in;
         run_last_ff   <= run_last_in;
         frame_last_ff <= frame_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   a_frame_ends_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff && frame_last_ff |-> run_last_ff)
      else $error("frame end word without run end");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(4))
      else $error("step index out of range");

   a_mid_command_head: assert property (@(posedge clock) disable iff (reset)
      step_ff != '0 |-> head_valid)
      else $error("command in progress without head entry");

   a_step_restart: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> step_ff == '0)
      else $error("step not cleared after command retired");

endmodule

// ===== hw/rtl/ubx_message_framer_top.sv =====
// UBX framer top level: sync, class, id, length, payload, Fletcher-8 checksum.
// Each byte is registered in the queue, then each word in the output register.
// While rsp_pop stays high: one payload byte per cycle; class, id and last payload
// bytes emit three words (id with empty payload five), one per cycle from the back end.
// A four-entry command queue absorbs those bursts; req_full rises when it fills.
// Reset (synchronous): queue and output register empty, framer awaits a class byte.
`timescale 1ns / 1ps

module ubx_message_framer_top import ubxf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_msg_byte,
   input  logic [15:0] req_payload_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_last
);

   logic    q_full;
   logic    q_push;
   cmd_type q_data;
   logic    head_valid;
   cmd_type head;
   logic    head_pop;

   assign req_full = q_full;

   ubxf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_msg_byte       (req_msg_byte),
      .req_payload_length (req_payload_length),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_data             (q_data)
   );

   ubxf_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (head_pop)
   );

   ubxf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .head_pop       (head_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
